FILE: rtl/dws_pkg.sv
// dws_pkg: shared types and constants of the damped wave stencil step block
// no dependencies; imported by the stencil core, the step checker and the testbench
package dws_pkg;

  // payload widths
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ROW_OUT_W  = 12;
  localparam int unsigned COL_OUT_W  = 6;
  localparam int unsigned FRAC_BITS  = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned KEEP_W     = 17;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned ROWS_W     = 13;
  localparam int unsigned COLS_CFG_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_KEEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = 3'd4;

  // reset values and grid limits
  localparam int unsigned LAP_GAIN_RST = 6554;
  localparam int unsigned KEEP_RST     = 65405;
  localparam int unsigned DT_RST       = 6554;
  localparam int unsigned ROWS_RST     = 25;
  localparam int unsigned COLS_RST     = 50;
  localparam int unsigned ROWS_MIN     = 3;
  localparam int unsigned ROWS_MAX     = 4096;
  localparam int unsigned COLS_MIN     = 3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] u_in;
    logic signed [VALUE_W-1:0] v_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] u_out;
    logic signed [VALUE_W-1:0] v_out;
    logic [ROW_OUT_W-1:0]      cell_row;
    logic [COL_OUT_W-1:0]      cell_col;
    logic                      frame_last;
  } out_item_t;

endpackage

FILE: rtl/dws_stream_if.sv
// dws_stream_if: valid/ready stream channel carrying one payload item per transfer
// depends on the payload type given as a parameter (types from dws_pkg)
interface dws_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dws_cell.sv
// dws_cell: one storage cell of a line chain, takes its neighbor's word or a new word
// no dependencies
module dws_cell #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         shift_i,
  input  logic         inject_i,
  input  logic [W-1:0] inj_data_i,
  input  logic [W-1:0] prev_data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] data_d, data_q;

  // the cell at the chain head loads the new word, the others take the neighbor's
  assign data_d = inject_i ? inj_data_i : prev_data_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

FILE: rtl/dws_line_chain.sv
// dws_line_chain: row of dws_cell cells forming a delay line of run-time length
// depends on dws_cell; the head cell is picked by start_i, the tail is fixed
module dws_line_chain #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned KW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic [KW-1:0] start_i,
  input  logic [W-1:0]  data_i,
  output logic [W-1:0]  tail_o,
  output logic [W-1:0]  next_o
);

  logic [W-1:0] cell_q [DEPTH];

  // cells pass data toward index DEPTH-1; words enter at start_i
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [W-1:0] prev;
    if (k == 0) begin : g_first
      assign prev = data_i;
    end else begin : g_rest
      assign prev = cell_q[k-1];
    end
    dws_cell #(.W(W)) u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift_i),
      .inject_i    (start_i == KW'(k)),
      .inj_data_i  (data_i),
      .prev_data_i (prev),
      .data_o      (cell_q[k])
    );
  end

  assign tail_o = cell_q[DEPTH-1];
  assign next_o = cell_q[DEPTH-2];

endmodule

FILE: rtl/damped_wave_stencil_step_core.sv
// damped_wave_stencil_step_core: one damped wave time step on a streamed grid
// depends on dws_pkg, dws_stream_if and dws_line_chain (built from dws_cell)
//
// Usage: grid cells (u_in, v_in) enter on in_i in raster order, one cell per
// transfer; each interior cell's update leaves on out_o once the cell below it
// has entered, with its row and column and frame_last on the last one of the
// sweep. Edge cells give no output. Two chains of cells hold the previous two
// rows of u and the previous row of v; each chain is as long as the grid has
// columns, so a transfer shifts them once and the stencil taps sit at the tail.
// Throughput: one cell per cycle while out_o is not stalled. An update passes
// through the five register stages of the update path (sum, two products,
// saturate, product, saturate), the first of which loads at the transfer edge
// of the cell below it. When out_o is stalled the whole path holds and in_i
// drops ready. Configuration writes go through cfg_we_i/cfg_idx_i/cfg_data_i
// only while the block is idle: the user must keep to this, the block itself
// does not enforce it. Grid sizes are clamped when written. Reset clears the
// counters, the stage valid bits and restores the register defaults; the line
// chains hold no reset and are valid once two rows have passed.
module damped_wave_stencil_step_core #(
  parameter int unsigned COLS_MAX = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dws_stream_if.sink                        in_i,
  dws_stream_if.source                      out_o,
  input  logic                              cfg_we_i,
  input  logic [dws_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dws_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import dws_pkg::*;

  localparam int unsigned CW      = $clog2(COLS_MAX);
  localparam int unsigned KW      = $clog2(COLS_MAX + 1);
  localparam int unsigned LAP_W   = VALUE_W + 3;
  localparam int unsigned SUM_W   = LAP_W + 2;
  localparam int unsigned M1_W    = VALUE_W + KEEP_W + 1;
  localparam int unsigned M2_W    = LAP_W + GAIN_W + 1;
  localparam int unsigned M3_W    = VALUE_W + DT_W + 1;
  localparam int unsigned P1_W    = M1_W - FRAC_BITS;
  localparam int unsigned P2_W    = M2_W - FRAC_BITS;
  localparam int unsigned P3_W    = M3_W - FRAC_BITS;
  localparam int unsigned COLS_R  = (COLS_RST > COLS_MAX) ? COLS_MAX : COLS_RST;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic signed [VALUE_W-1:0] sat_v(input logic signed [SUM_W-1:0] x);
    logic signed [VALUE_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[VALUE_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[VALUE_W-1:0];
    end else begin
      r = x[VALUE_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [GAIN_W-1:0] gain_q;
  logic [KEEP_W-1:0] keep_q;
  logic [DT_W-1:0]   dt_q;
  logic [ROWS_W-1:0] rows_q;
  logic [KW-1:0]     cols_q;
  logic [ROWS_W-1:0] rows_wr;
  logic [KW-1:0]     cols_wr;

  // grid sizes are clamped on the way in
  always_comb begin
    if (32'(cfg_data_i[ROWS_W-1:0]) < ROWS_MIN) begin
      rows_wr = ROWS_W'(ROWS_MIN);
    end else if (32'(cfg_data_i[ROWS_W-1:0]) > ROWS_MAX) begin
      rows_wr = ROWS_W'(ROWS_MAX);
    end else begin
      rows_wr = cfg_data_i[ROWS_W-1:0];
    end
    if (32'(cfg_data_i[COLS_CFG_W-1:0]) < COLS_MIN) begin
      cols_wr = KW'(COLS_MIN);
    end else if (32'(cfg_data_i[COLS_CFG_W-1:0]) > COLS_MAX) begin
      cols_wr = KW'(COLS_MAX);
    end else begin
      cols_wr = KW'(cfg_data_i[COLS_CFG_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_W'(LAP_GAIN_RST);
      keep_q <= KEEP_W'(KEEP_RST);
      dt_q   <= DT_W'(DT_RST);
      rows_q <= ROWS_W'(ROWS_RST);
      cols_q <= KW'(COLS_R);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LAP_GAIN:      gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_VELOCITY_KEEP: keep_q <= cfg_data_i[KEEP_W-1:0];
        REG_STEP_DT:       dt_q   <= cfg_data_i[DT_W-1:0];
        REG_GRID_ROWS:     rows_q <= rows_wr;
        REG_GRID_COLS:     cols_q <= cols_wr;
        default:           ;
      endcase
    end
  end

  // pipeline control: the whole path holds while the output is stalled
  logic stall, adv, in_xfer;
  logic in_ready;
  logic out_valid_q;
  out_item_t out_q;

  assign stall    = out_valid_q && !out_o.ready;
  assign adv      = !stall;
  assign in_ready = adv;
  assign in_i.ready = in_ready;
  assign in_xfer  = in_i.valid && in_ready;

  // position of the incoming cell
  logic [ROW_OUT_W-1:0] row_q, row_d;
  logic [CW-1:0]        col_q, col_d;
  logic [ROWS_W-1:0]    r0, r1;
  logic [KW:0]          c0, c1, c2, cols_x;
  logic in_grid, edge_cell, center, emit, last_cell, shift_en;

  always_comb begin
    r0        = ROWS_W'(row_q);
    r1        = r0 + ROWS_W'(1);
    c0        = (KW+1)'(col_q);
    c1        = c0 + (KW+1)'(1);
    c2        = c0 + (KW+1)'(2);
    cols_x    = (KW+1)'(cols_q);
    in_grid   = (r0 < rows_q) && (c0 < cols_x);
    edge_cell = (row_q == '0) || (r1 >= rows_q) || (col_q == '0) || (c1 >= cols_x);
    center    = in_grid && !edge_cell;
    emit      = in_grid && (row_q >= ROW_OUT_W'(2)) && (col_q != '0) && (c2 <= cols_x);
    last_cell = (r1 == rows_q) && (c2 == cols_x);
    shift_en  = in_xfer && in_grid;
    if (c1 >= cols_x) begin
      col_d = '0;
      row_d = (r1 >= rows_q) ? '0 : row_q + ROW_OUT_W'(1);
    end else begin
      col_d = CW'(c1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_xfer) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // line chains: previous row of u and v, and the row before it of u
  logic signed [VALUE_W-1:0] u_eff, v_eff;
  logic [2*VALUE_W-1:0] ch1_tail, ch1_next;
  logic [VALUE_W-1:0]   ch2_tail, ch2_next;
  logic [VALUE_W-1:0]   left_q;
  logic [KW-1:0]        start;

  assign u_eff = center ? in_i.data.u_in : '0;
  assign v_eff = center ? in_i.data.v_in : '0;
  assign start = KW'(COLS_MAX) - cols_q;

  dws_line_chain #(.W(2*VALUE_W), .DEPTH(COLS_MAX), .KW(KW)) u_chain_prev (
    .clk_i   (clk_i),
    .shift_i (shift_en),
    .start_i (start),
    .data_i  ({u_eff, v_eff}),
    .tail_o  (ch1_tail),
    .next_o  (ch1_next)
  );

  dws_line_chain #(.W(VALUE_W), .DEPTH(COLS_MAX), .KW(KW)) u_chain_old (
    .clk_i   (clk_i),
    .shift_i (shift_en),
    .start_i (start),
    .data_i  (ch1_tail[2*VALUE_W-1:VALUE_W]),
    .tail_o  (ch2_tail),
    .next_o  (ch2_next)
  );

  // word that left the previous-row chain last is the left neighbor
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      left_q <= ch1_tail[2*VALUE_W-1:VALUE_W];
    end
  end

  // stage 1: laplacian
  logic signed [VALUE_W-1:0] above, mid, right, left, vold;
  logic signed [LAP_W-1:0]   lap;
  assign above = $signed(ch2_tail);
  assign mid   = $signed(ch1_tail[2*VALUE_W-1:VALUE_W]);
  assign vold  = $signed(ch1_tail[VALUE_W-1:0]);
  assign right = $signed(ch1_next[2*VALUE_W-1:VALUE_W]);
  assign left  = $signed(left_q);
  assign lap   = LAP_W'(above) + LAP_W'(u_eff) + LAP_W'(left) + LAP_W'(right)
               - (LAP_W'(mid) <<< 2);

  logic                      s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic signed [LAP_W-1:0]   s1_lap_q;
  logic signed [VALUE_W-1:0] s1_vold_q, s1_mid_q, s2_mid_q, s3_mid_q, s4_mid_q;
  logic [ROW_OUT_W-1:0]      s1_row_q, s2_row_q, s3_row_q, s4_row_q;
  logic [COL_OUT_W-1:0]      s1_col_q, s2_col_q, s3_col_q, s4_col_q;
  logic                      s1_last_q, s2_last_q, s3_last_q, s4_last_q;
  logic signed [P1_W-1:0]    s2_p1_q;
  logic signed [P2_W-1:0]    s2_p2_q;
  logic signed [VALUE_W-1:0] s3_vn_q, s4_vn_q;
  logic signed [P3_W-1:0]    s4_p3_q;

  // product terms, truncated toward minus infinity
  logic signed [M1_W-1:0] m1;
  logic signed [M2_W-1:0] m2;
  logic signed [M3_W-1:0] m3;
  logic signed [SUM_W-1:0] vsum, usum;
  assign m1   = M1_W'(s1_vold_q) * M1_W'($signed({1'b0, keep_q}));
  assign m2   = M2_W'(s1_lap_q) * M2_W'($signed({1'b0, gain_q}));
  assign m3   = M3_W'(s3_vn_q) * M3_W'($signed({1'b0, dt_q}));
  assign vsum = SUM_W'(s2_p1_q) + SUM_W'(s2_p2_q);
  assign usum = SUM_W'(s4_mid_q) + SUM_W'(s4_p3_q);

  // valid bits of the update path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= in_xfer && emit;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      out_valid_q <= s4_vld_q;
    end
  end

  // payload of the update path
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lap_q   <= lap;
      s1_vold_q  <= vold;
      s1_mid_q   <= mid;
      s1_row_q   <= row_q - ROW_OUT_W'(1);
      s1_col_q   <= COL_OUT_W'(col_q);
      s1_last_q  <= last_cell;
      s2_p1_q    <= $signed(m1[M1_W-1:FRAC_BITS]);
      s2_p2_q    <= $signed(m2[M2_W-1:FRAC_BITS]);
      s2_mid_q   <= s1_mid_q;
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      s2_last_q  <= s1_last_q;
      s3_vn_q    <= sat_v(vsum);
      s3_mid_q   <= s2_mid_q;
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
      s3_last_q  <= s2_last_q;
      s4_p3_q    <= $signed(m3[M3_W-1:FRAC_BITS]);
      s4_vn_q    <= s3_vn_q;
      s4_mid_q   <= s3_mid_q;
      s4_row_q   <= s3_row_q;
      s4_col_q   <= s3_col_q;
      s4_last_q  <= s3_last_q;
      out_q.u_out      <= sat_v(usum);
      out_q.v_out      <= s4_vn_q;
      out_q.cell_row   <= s4_row_q;
      out_q.cell_col   <= s4_col_q;
      out_q.frame_last <= s4_last_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef ASSERT_OFF
  // a stalled output blocks new input transfers
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> !in_i.ready) else $error("input accepted while output stalled");

  // a result in the last stage reaches the output register when not stalled
  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_vld_q && !stall) |=> out_valid_q) else $error("result lost before output");

  // the update path holds its contents while stalled
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> ($stable(s4_vld_q) && $stable(s1_vld_q))) else $error("pipeline moved in stall");

  // interior results never name row zero
  a_row_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.cell_row != '0)) else $error("result on top edge row");

  // the line chains move only on an input transfer
  a_shift_on_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_en |-> (in_i.valid && in_i.ready)) else $error("line chain shifted without transfer");
`endif

endmodule

FILE: dv/dws_step_checker.sv
// dws_step_checker: predicts each damped wave update from the observed transfers and compares
// depends on dws_pkg; watches the in/out channels and the config port of the stencil core
module dws_step_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  dws_pkg::in_item_t               in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  dws_pkg::out_item_t              out_data_i,
  input  logic                            cfg_we_i,
  input  logic [dws_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dws_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import dws_pkg::*;

  localparam int unsigned LINE_DEPTH = 64;

  // predictor copy of the registers
  int unsigned gain_q, keep_q, dt_q, rows_q, cols_q;
  // line stores and raster position
  longint u_line[2][LINE_DEPTH];
  longint v_line[LINE_DEPTH];
  int unsigned row_pos, col_pos;
  out_item_t updates_due[$];

  // floor(x * k / 2^16)
  function automatic longint scale_q16(longint x, int unsigned k);
    longint prod;
    prod = x * longint'(k);
    return prod >>> FRAC_BITS;
  endfunction

  function automatic longint clip_value(longint x);
    longint hi, lo;
    hi = (longint'(1) <<< (VALUE_W - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // one cell enters: maybe one update of the cell above it
  function automatic void take_cell(in_item_t cell_in);
    int unsigned nrows, ncols, cur, prv;
    bit in_grid, edge_cell;
    longint u, v, above, mid, left, right, lap, vn, un;
    out_item_t upd;
    nrows = rows_q < ROWS_MIN ? ROWS_MIN : (rows_q > ROWS_MAX ? ROWS_MAX : rows_q);
    ncols = cols_q < COLS_MIN ? COLS_MIN : (cols_q > LINE_DEPTH ? LINE_DEPTH : cols_q);
    in_grid = (row_pos < nrows) && (col_pos < ncols);
    edge_cell = (row_pos == 0) || (row_pos + 1 >= nrows) || (col_pos == 0) ||
                (col_pos + 1 >= ncols);
    u = (in_grid && !edge_cell) ? longint'(cell_in.u_in) : 0;
    v = (in_grid && !edge_cell) ? longint'(cell_in.v_in) : 0;
    if (in_grid) begin
      cur = row_pos & 1;
      prv = (row_pos + 1) & 1;
      if (row_pos >= 2 && col_pos >= 1 && col_pos + 2 <= ncols) begin
        above = u_line[cur][col_pos];
        mid   = u_line[prv][col_pos];
        left  = u_line[prv][col_pos-1];
        right = u_line[prv][col_pos+1];
        lap = above + u + left + right - 4 * mid;
        vn = clip_value(scale_q16(v_line[col_pos], keep_q) + scale_q16(lap, gain_q));
        un = clip_value(mid + scale_q16(vn, dt_q));
        upd.u_out      = un[VALUE_W-1:0];
        upd.v_out      = vn[VALUE_W-1:0];
        upd.cell_row   = ROW_OUT_W'(row_pos - 1);
        upd.cell_col   = COL_OUT_W'(col_pos);
        upd.frame_last = (row_pos + 1 == nrows) && (col_pos + 2 == ncols);
        updates_due.push_back(upd);
      end
      u_line[cur][col_pos] = u;
      v_line[col_pos] = v;
    end
    if (col_pos + 1 >= ncols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= nrows) ? 0 : ((row_pos + 1) & 12'hfff);
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // compare one update against the oldest prediction
  function automatic void check_update(out_item_t got);
    out_item_t want;
    if (updates_due.size() == 0) begin
      $error("unexpected update at row %0d col %0d", got.cell_row, got.cell_col);
      fail_count_o++;
      return;
    end
    want = updates_due.pop_front();
    checked_o++;
    if (got.u_out !== want.u_out) begin
      $error("u_out expected %0d got %0d", want.u_out, got.u_out);
      fail_count_o++;
    end
    if (got.v_out !== want.v_out) begin
      $error("v_out expected %0d got %0d", want.v_out, got.v_out);
      fail_count_o++;
    end
    if (got.cell_row !== want.cell_row) begin
      $error("cell_row expected %0d got %0d", want.cell_row, got.cell_row);
      fail_count_o++;
    end
    if (got.cell_col !== want.cell_col) begin
      $error("cell_col expected %0d got %0d", want.cell_col, got.cell_col);
      fail_count_o++;
    end
    if (got.frame_last !== want.frame_last) begin
      $error("frame_last expected %0d got %0d", want.frame_last, got.frame_last);
      fail_count_o++;
    end
  endfunction

  initial begin
    fail_count_o = 0;
    checked_o = 0;
  end

  assign pending_o = updates_due.size();

  // register writes, cell transfers and update transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  = LAP_GAIN_RST;
      keep_q  = KEEP_RST;
      dt_q    = DT_RST;
      rows_q  = ROWS_RST;
      cols_q  = COLS_RST;
      row_pos = 0;
      col_pos = 0;
      updates_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LAP_GAIN:      gain_q = cfg_data_i & 17'h0ffff;
          REG_VELOCITY_KEEP: keep_q = cfg_data_i & 17'h1ffff;
          REG_STEP_DT:       dt_q   = cfg_data_i & 17'h0ffff;
          REG_GRID_ROWS:     rows_q = cfg_data_i & 17'h01fff;
          REG_GRID_COLS:     cols_q = cfg_data_i & 17'h0007f;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_update(out_data_i);
      if (in_valid_i && in_ready_i) take_cell(in_data_i);
    end
  end
endmodule

FILE: dv/tb.sv
// tb: stimulus and verdict for damped_wave_stencil_step_core
// depends on dws_pkg, dws_stream_if, the core and dws_step_checker
module tb;
  import dws_pkg::*;

  localparam int unsigned RUN_LIMIT  = 800000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned RAND_CELLS = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic hold_req;
  bit calm;
  int fail_count, pending, checked;
  int unsigned cycle_count = 0;
  int unsigned cells_sent = 0;
  int unsigned sweeps_done = 0;

  dws_stream_if #(.item_t(in_item_t))  in_ch ();
  dws_stream_if #(.item_t(out_item_t)) out_ch ();

  damped_wave_stencil_step_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  dws_step_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // update receiver: random stalls per transfer, one long hold on request
  initial begin
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) stall_left = calm ? 0 : $urandom_range(0, 6);
      if (hold_req) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return VALUE_W'($signed($urandom_range(0, 32'h007fffff)) - 32'sh00400000);
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk_i);
  endtask

  // all five registers in one burst, then the enable drops
  task automatic set_regs(int unsigned gain, int unsigned keep, int unsigned dt,
                          int unsigned nrows, int unsigned ncols);
    reg_write(REG_LAP_GAIN, gain);
    reg_write(REG_VELOCITY_KEEP, keep);
    reg_write(REG_STEP_DT, dt);
    reg_write(REG_GRID_ROWS, nrows);
    reg_write(REG_GRID_COLS, ncols);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_cell(logic [VALUE_W-1:0] u, logic [VALUE_W-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{u_in: u, v_in: v};
    do @(posedge clk_i); while (!in_ch.ready);
    cells_sent++;
  endtask

  // idle the sender until every update has left
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // one full sweep; optional long receiver hold part way through
  task automatic sweep(int unsigned nrows, int unsigned ncols, bit with_hold);
    for (int unsigned i = 0; i < nrows * ncols; i++) begin
      if (with_hold && i == ncols + 2) hold_req <= 1'b1;
      else hold_req <= 1'b0;
      send_cell(pick_value(), pick_value());
    end
    hold_req <= 1'b0;
    drain();
    sweeps_done++;
  endtask

  function automatic int unsigned pick_coef(int unsigned top);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  initial begin
    int unsigned first_random, nrows, ncols, phase;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    calm = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset coefficients, 5x5 grid of extreme values
    reg_write(REG_GRID_ROWS, 5);
    reg_write(REG_GRID_COLS, 5);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    for (int unsigned i = 0; i < 25; i++) begin
      case (i % 4)
        0: send_cell(32'h7fffffff, 32'h7fffffff);
        1: send_cell(32'h80000000, 32'h80000000);
        2: send_cell(32'h00000000, 32'hffffffff);
        default: send_cell(32'h7fffffff, 32'h80000000);
      endcase
    end
    drain();
    sweeps_done++;

    // smallest grid with gain and dt at their maximum and velocity keep at 65536
    set_regs(16'hffff, 65536, 16'hffff, 3, 3);
    sweep(3, 3, 1'b0);

    // grid sizes below the minimum are clamped to the smallest grid
    set_regs(pick_coef(16'hffff), pick_coef(65536), pick_coef(16'hffff), 1, 2);
    sweep(3, 3, 1'b0);

    // random settings and sweeps; wide grid with a long receiver hold
    first_random = cells_sent;
    phase = 0;
    while (cells_sent - first_random < RAND_CELLS) begin
      calm = (phase % 4 == 3);
      if (phase == 1) begin
        nrows = 4;
        ncols = 64;
      end else begin
        nrows = $urandom_range(3, 8);
        ncols = $urandom_range(3, 12);
      end
      set_regs(pick_coef(16'hffff), pick_coef(65536), pick_coef(16'hffff), nrows, ncols);
      sweep(nrows, ncols, phase == 1);
      phase++;
    end
    calm = 1'b0;

    $display("covered %0d sweeps, %0d cells in, %0d updates compared",
             sweeps_done, cells_sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
